// ----- design/psbip_pkg.sv -----
// shared types and constants of the pcm sample buffer with interpolated playback
// no dependencies
package psbip_pkg;

  localparam int unsigned PSBIP_MAX_FRAMES   = 4096;
  localparam int unsigned PSBIP_MAX_CHANNELS = 2;

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] REG_FRAME_COUNT   = 2'd2;
  localparam logic [1:0] REG_VOLUME_Q15    = 2'd3;

  // sample formats
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S24 = 2'd2;
  localparam logic [1:0] FMT_F32 = 2'd3;

  // operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // multiplier operand selects
  localparam logic [1:0] MS_NEAR = 2'd0;
  localparam logic [1:0] MS_FAR  = 2'd1;
  localparam logic [1:0] MS_VOL  = 2'd2;
  localparam logic [1:0] MS_FLT  = 2'd3;

  localparam int unsigned PROD_W = 52;
  localparam int unsigned ACC_W  = 34;

  typedef struct packed {
    logic        operation;
    logic [31:0] raw_sample;
    logic [1:0]  channel;
    logic [11:0] position_whole;
    logic [15:0] position_fraction;
  } psbip_in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               range_error;
  } psbip_out_t;

  typedef struct packed {
    logic signed [15:0]      sample;
    logic [15:0]             frac;
    logic signed [ACC_W-1:0] acc;
    logic [15:0]             vol;
    logic [23:0]             mant;
  } psbip_mul_opnd_t;

endpackage

// ----- design/psbip_mul.sv -----
// shared signed multiplier with operand selection and registered product
// depends on psbip_pkg
module psbip_mul import psbip_pkg::*; (
  input  logic                     clk_i,
  input  logic [1:0]               sel_i,
  input  psbip_mul_opnd_t          opnd_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [ACC_W-1:0]  a;
  logic signed [17:0]       b;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  always_comb begin
    case (sel_i)
      MS_NEAR: begin
        a = ACC_W'(opnd_i.sample);
        b = 18'sd65536 - $signed({2'b00, opnd_i.frac});
      end
      MS_FAR: begin
        a = ACC_W'(opnd_i.sample);
        b = $signed({2'b00, opnd_i.frac});
      end
      MS_VOL: begin
        a = opnd_i.acc;
        b = $signed({2'b00, opnd_i.vol});
      end
      MS_FLT: begin
        a = $signed({10'd0, opnd_i.mant});
        b = 18'sd32767;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
    prod_d = PROD_W'(a) * PROD_W'(b);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ----- design/pcm_sample_buffer_interp_playback_core.sv -----
// top level of the pcm sample buffer: format conversion, store, interpolated read
// depends on psbip_pkg and psbip_mul
//
// channel   ports                                 handshake
// config    cfg_we_i cfg_idx_i cfg_wdata_i        write when cfg_we_i high
// command   start_i busy_o in_i                   taken when start_i high and busy_o low
// result    result_valid_o result_o               one-cycle strobe, no back-pressure
//
// a load of 8, 16 or 24 bit samples is stored when it is taken, a float load after
// the steps multiply, then shift and saturate; an in-range read is paced by
// two sequential reads of the store's one read port and three passes through the
// one shared multiplier; an out-of-range read is answered straight from idle.
// the word appears the cycle after the last step; busy_o drops at the same time.
// the store is not cleared by reset; reset clears state and pointers, presets config
module pcm_sample_buffer_interp_playback_core import psbip_pkg::*; #(
  parameter int unsigned MAX_FRAMES   = PSBIP_MAX_FRAMES,
  parameter int unsigned MAX_CHANNELS = PSBIP_MAX_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  psbip_in_t   in_i,
  output logic        result_valid_o,
  output psbip_out_t  result_o
);

  localparam int unsigned Depth = MAX_FRAMES * MAX_CHANNELS;
  localparam int unsigned AW    = $clog2(Depth);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NEAR = 3'd1;
  localparam logic [2:0] ST_FAR  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_VOL  = 3'd4;
  localparam logic [2:0] ST_RES  = 3'd5;
  localparam logic [2:0] ST_FMUL = 3'd6;
  localparam logic [2:0] ST_FOUT = 3'd7;

  logic [1:0]  fmt_q;
  logic [1:0]  chan_cnt_q;
  logic [12:0] frame_cnt_q;
  logic [15:0] vol_q;

  logic [2:0]  state_q, state_d;
  logic [12:0] wr_frame_q, wr_frame_d;
  logic [1:0]  wr_chan_q, wr_chan_d;
  psbip_out_t  out_q, out_d;
  logic        out_valid_q, out_valid_d;

  psbip_in_t               in_q;
  logic [AW-1:0]           addr2_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [15:0]      rdata_q;
  logic [15:0]             store_mem [Depth];

  logic [3:0]  chans;
  logic [12:0] frames;
  logic        accept;

  logic [3:0]  rd_chan;
  logic [12:0] rd_next;
  logic [AW-1:0] addr1, addr2, raddr, waddr;
  logic [3:0]  wch;
  logic        mem_we;
  logic signed [15:0] load_val, conv_val, flt_val;
  logic        load_err;
  logic        do_store;

  logic [1:0]  mul_sel;
  psbip_mul_opnd_t         opnd;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] blend_t, vol_t;
  logic signed [20:0]       vol_q31;

  logic [7:0]  f_ex, f_ex_eff, f_sh;
  logic [22:0] f_man;
  logic [38:0] f_mag;

  assign accept = start_i & ~busy_o;
  assign busy_o = (state_q != ST_IDLE);

  // effective channel and frame counts
  always_comb begin
    if (chan_cnt_q == 2'd0) begin
      chans = 4'd1;
    end else if (32'(chan_cnt_q) > MAX_CHANNELS) begin
      chans = 4'(MAX_CHANNELS);
    end else begin
      chans = {2'b00, chan_cnt_q};
    end
    if (frame_cnt_q == 13'd0) begin
      frames = 13'd1;
    end else if (32'(frame_cnt_q) > MAX_FRAMES) begin
      frames = 13'(MAX_FRAMES);
    end else begin
      frames = frame_cnt_q;
    end
  end

  // read addresses
  always_comb begin
    rd_chan = ({2'b00, in_i.channel} >= chans) ? chans - 4'd1 : {2'b00, in_i.channel};
    rd_next = {1'b0, in_i.position_whole} + 13'd1;
    if (rd_next >= frames) begin
      rd_next = '0;
    end
    addr1 = AW'(32'(in_i.position_whole) * 32'(MAX_CHANNELS) + 32'(rd_chan));
    addr2 = AW'(32'(rd_next) * 32'(MAX_CHANNELS) + 32'(rd_chan));
    raddr = (state_q == ST_NEAR) ? addr2_q : addr1;
  end

  // fixed-point conversions
  always_comb begin
    case (fmt_q)
      FMT_U8:  conv_val = {~in_i.raw_sample[7], ~in_i.raw_sample[7],
                           in_i.raw_sample[6:0], 7'd0};
      FMT_S16: conv_val = in_i.raw_sample[15:0];
      FMT_S24: conv_val = in_i.raw_sample[23:8];
      default: conv_val = '0;
    endcase
  end

  // float conversion, product of mantissa and full scale taken from the multiplier
  always_comb begin
    f_ex     = in_q.raw_sample[30:23];
    f_man    = in_q.raw_sample[22:0];
    f_ex_eff = (f_ex == 8'd0) ? 8'd1 : f_ex;
    f_sh     = 8'd150 - f_ex_eff;
    f_mag    = (f_sh >= 8'd39) ? 39'd0 : (prod[38:0] >> f_sh);
    if (f_ex == 8'hFF) begin
      if (f_man != 23'd0) begin
        flt_val = '0;
      end else begin
        flt_val = in_q.raw_sample[31] ? 16'sh8000 : 16'sh7FFF;
      end
    end else if (f_ex_eff >= 8'd141) begin
      flt_val = in_q.raw_sample[31] ? 16'sh8000 : 16'sh7FFF;
    end else if (in_q.raw_sample[31]) begin
      flt_val = (f_mag >= 39'd32768) ? 16'sh8000 : -$signed(f_mag[15:0]);
    end else begin
      flt_val = (f_mag > 39'd32767) ? 16'sh7FFF : $signed(f_mag[15:0]);
    end
  end

  // interpolation arithmetic
  always_comb begin
    blend_t = prod + (prod[PROD_W-1] ? PROD_W'(65535) : '0);
    vol_t   = prod + (prod[PROD_W-1] ? PROD_W'(32'h7FFF_FFFF) : '0);
    vol_q31 = vol_t[51:31];
  end

  // store write side
  always_comb begin
    wch      = ({2'b00, wr_chan_q} >= chans) ? chans - 4'd1 : {2'b00, wr_chan_q};
    waddr    = AW'(32'(wr_frame_q) * 32'(MAX_CHANNELS) + 32'(wch));
    load_err = (wr_frame_q >= frames);
    load_val = (state_q == ST_FOUT) ? flt_val : conv_val;
    do_store = ((state_q == ST_IDLE) && accept && (in_i.operation == OP_LOAD)
                && (fmt_q != FMT_F32)) || (state_q == ST_FOUT);
    mem_we   = do_store && !load_err;
  end

  always_comb begin
    opnd.sample = rdata_q;
    opnd.frac   = in_q.position_fraction;
    opnd.acc    = acc_q;
    opnd.vol    = vol_q;
    opnd.mant   = (in_q.raw_sample[30:23] == 8'd0) ? {1'b0, in_q.raw_sample[22:0]}
                                                   : {1'b1, in_q.raw_sample[22:0]};
    case (state_q)
      ST_NEAR: mul_sel = MS_NEAR;
      ST_FAR:  mul_sel = MS_FAR;
      ST_VOL:  mul_sel = MS_VOL;
      ST_FMUL: mul_sel = MS_FLT;
      default: mul_sel = MS_FLT;
    endcase
  end

  psbip_mul u_mul (
    .clk_i  (clk_i),
    .sel_i  (mul_sel),
    .opnd_i (opnd),
    .prod_o (prod)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    wr_frame_d  = wr_frame_q;
    wr_chan_d   = wr_chan_q;
    out_d       = out_q;
    out_valid_d = 1'b0;
    acc_d       = acc_q;
    if (do_store) begin
      out_d.sample_out  = load_val;
      out_d.range_error = load_err;
      out_valid_d       = 1'b1;
      if (!load_err) begin
        if (wch + 4'd1 >= chans) begin
          wr_chan_d  = '0;
          wr_frame_d = wr_frame_q + 13'd1;
        end else begin
          wr_chan_d = 2'(wch + 4'd1);
        end
      end
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.operation == OP_READ) begin
            if ({1'b0, in_i.position_whole} >= frames) begin
              out_d.sample_out  = '0;
              out_d.range_error = 1'b1;
              out_valid_d       = 1'b1;
            end else begin
              state_d = ST_NEAR;
            end
          end else if (fmt_q == FMT_F32) begin
            state_d = ST_FMUL;
          end
        end
      end
      ST_NEAR: state_d = ST_FAR;
      ST_FAR: begin
        acc_d   = prod[ACC_W-1:0];
        state_d = ST_SUM;
      end
      ST_SUM: begin
        acc_d   = acc_q + {blend_t[33:16], 16'h0000};
        state_d = ST_VOL;
      end
      ST_VOL: state_d = ST_RES;
      ST_RES: begin
        if (vol_q31 > 21'sd32767) begin
          out_d.sample_out = 16'sh7FFF;
        end else if (vol_q31 < -21'sd32768) begin
          out_d.sample_out = 16'sh8000;
        end else begin
          out_d.sample_out = vol_q31[15:0];
        end
        out_d.range_error = 1'b0;
        out_valid_d       = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_FMUL: state_d = ST_FOUT;
      ST_FOUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_frame_q  <= '0;
      wr_chan_q   <= '0;
      out_valid_q <= 1'b0;
      fmt_q       <= FMT_S16;
      chan_cnt_q  <= 2'd1;
      frame_cnt_q <= 13'd4096;
      vol_q       <= 16'd32768;
    end else begin
      state_q     <= state_d;
      wr_frame_q  <= wr_frame_d;
      wr_chan_q   <= wr_chan_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SAMPLE_FORMAT: fmt_q       <= cfg_wdata_i[1:0];
          REG_CHANNEL_COUNT: chan_cnt_q  <= cfg_wdata_i[1:0];
          REG_FRAME_COUNT:   frame_cnt_q <= cfg_wdata_i[12:0];
          REG_VOLUME_Q15:    vol_q       <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    acc_q <= acc_d;
    if (accept) begin
      in_q    <= in_i;
      addr2_q <= addr2;
    end
  end

  // sample store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[waddr] <= load_val;
    end
    rdata_q <= store_mem[raddr];
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

// ----- dv/tb.sv -----
// testbench of pcm_sample_buffer_interp_playback_core: sample loads in all formats and
// interpolated reads, checked word by word against a behavioral predictor of the core
// depends on psbip_pkg and the rtl of the core
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psbip_pkg::*;

  localparam int unsigned STORE_DEPTH  = PSBIP_MAX_FRAMES * PSBIP_MAX_CHANNELS;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_WORDS = 500;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        start_i     = 1'b0;
  logic        busy_o;
  psbip_in_t   in_i        = '0;
  logic        result_valid_o;
  psbip_out_t  result_o;

  // predictor state
  logic signed [15:0] pcm_store [STORE_DEPTH];
  bit                 pcm_written [STORE_DEPTH];
  int unsigned        wr_frame   = 0;
  int unsigned        wr_chan    = 0;
  logic [1:0]         fmt_reg    = FMT_S16;
  logic [1:0]         chans_reg  = 2'd1;
  logic [12:0]        frames_reg = 13'd4096;
  logic [15:0]        vol_reg    = 16'd32768;

  psbip_out_t  pending_words [$];
  psbip_out_t  want;
  int          fails       = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on     = 1'b1;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pcm_sample_buffer_interp_playback_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  function automatic int unsigned chans_used();
    if (chans_reg == 0) return 1;
    if (chans_reg > PSBIP_MAX_CHANNELS) return PSBIP_MAX_CHANNELS;
    return chans_reg;
  endfunction

  function automatic int unsigned frames_used();
    if (frames_reg == 0) return 1;
    if (frames_reg > PSBIP_MAX_FRAMES) return PSBIP_MAX_FRAMES;
    return frames_reg;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] float_to_pcm16(logic [31:0] w);
    int unsigned       ex;
    int unsigned       sh;
    longint unsigned   man;
    longint            mag;
    ex  = w[30:23];
    man = w[22:0];
    if (ex == 255) return (man != 0) ? 16'sh0000 : (w[31] ? 16'sh8000 : 16'sh7FFF);
    if (ex == 0) ex = 1;
    else man = man | 64'h80_0000;
    if (ex >= 141) begin
      mag = 1000000;
    end else begin
      sh  = 150 - ex;
      mag = (sh >= 40) ? 0 : longint'((man * 32767) >> sh);
    end
    return clamp16(w[31] ? -mag : mag);
  endfunction

  function automatic logic signed [15:0] to_pcm16(logic [31:0] raw);
    case (fmt_reg)
      FMT_U8:  return 16'((int'(raw[7:0]) - 128) * 128);
      FMT_S16: return raw[15:0];
      FMT_S24: return raw[23:8];
      default: return float_to_pcm16(raw);
    endcase
  endfunction

  function automatic bit readable(int unsigned ch, int unsigned pos);
    int unsigned chans;
    int unsigned frames;
    int unsigned nxt;
    chans  = chans_used();
    frames = frames_used();
    if (ch >= chans) ch = chans - 1;
    if (pos >= frames) return 1'b0;
    nxt = (pos + 1 >= frames) ? pos + 1 - frames : pos + 1;
    return pcm_written[pos * PSBIP_MAX_CHANNELS + ch] &&
           pcm_written[nxt * PSBIP_MAX_CHANNELS + ch];
  endfunction

  // expected word of one command, advancing the store and write pointers
  function automatic psbip_out_t playback_word(psbip_in_t cmd);
    psbip_out_t  w;
    int unsigned chans;
    int unsigned frames;
    int unsigned ch;
    int unsigned pos;
    int unsigned nxt;
    longint      f;
    longint      v1;
    longint      v2;
    longint      far_part;
    longint      blend;
    chans         = chans_used();
    frames        = frames_used();
    w.sample_out  = '0;
    w.range_error = 1'b0;
    if (cmd.operation == OP_LOAD) begin
      w.sample_out = to_pcm16(cmd.raw_sample);
      if (wr_frame >= frames) begin
        w.range_error = 1'b1;
      end else begin
        ch = (wr_chan >= chans) ? chans - 1 : wr_chan;
        pcm_store[wr_frame * PSBIP_MAX_CHANNELS + ch]   = w.sample_out;
        pcm_written[wr_frame * PSBIP_MAX_CHANNELS + ch] = 1'b1;
        if (ch + 1 >= chans) begin
          wr_chan = 0;
          wr_frame++;
        end else begin
          wr_chan = ch + 1;
        end
      end
    end else begin
      ch  = cmd.channel;
      pos = cmd.position_whole;
      f   = cmd.position_fraction;
      if (ch >= chans) ch = chans - 1;
      if (pos >= frames) begin
        w.range_error = 1'b1;
      end else begin
        nxt      = (pos + 1 >= frames) ? pos + 1 - frames : pos + 1;
        v1       = pcm_store[pos * PSBIP_MAX_CHANNELS + ch];
        v2       = pcm_store[nxt * PSBIP_MAX_CHANNELS + ch];
        far_part = (f * v2) / 65536;
        blend    = (65536 - f) * v1 + far_part * 65536;
        w.sample_out = clamp16((blend * longint'(vol_reg)) / (longint'(1) << 31));
      end
    end
    return w;
  endfunction

  function automatic psbip_in_t load_cmd(logic [31:0] raw);
    psbip_in_t c;
    c.operation         = OP_LOAD;
    c.raw_sample        = raw;
    c.channel           = $urandom;
    c.position_whole    = $urandom;
    c.position_fraction = $urandom;
    return c;
  endfunction

  function automatic psbip_in_t read_cmd(logic [1:0] ch, logic [11:0] pos, logic [15:0] frac);
    psbip_in_t c;
    c.operation         = OP_READ;
    c.raw_sample        = $urandom;
    c.channel           = ch;
    c.position_whole    = pos;
    c.position_fraction = frac;
    return c;
  endfunction

  function automatic logic [31:0] random_raw();
    logic [31:0] w;
    int unsigned pick;
    w = $urandom;
    if (fmt_reg != FMT_F32) return w;
    pick = $urandom_range(19);
    if (pick < 12) w[30:23] = $urandom_range(145, 100);
    else if (pick < 14) w[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
    return w;
  endfunction

  // mostly reads of written frames, some out-of-range reads, the rest loads
  function automatic psbip_in_t random_cmd();
    psbip_in_t   c;
    int unsigned frames;
    int unsigned hi;
    int unsigned tries;
    frames = frames_used();
    if ($urandom_range(99) < 45) return load_cmd(random_raw());
    c = read_cmd($urandom, '0, $urandom);
    if (frames < PSBIP_MAX_FRAMES && $urandom_range(9) == 0) begin
      c.position_whole = $urandom_range(PSBIP_MAX_FRAMES - 1, frames);
      return c;
    end
    hi = ((frames < wr_frame + 1) ? frames : wr_frame + 1) - 1;
    for (tries = 0; tries < 16; tries++) begin
      c.position_whole = $urandom_range(hi);
      if (readable(c.channel, c.position_whole)) return c;
      c.channel = $urandom;
    end
    if (frames < PSBIP_MAX_FRAMES) begin
      c.position_whole = $urandom_range(PSBIP_MAX_FRAMES - 1, frames);
      return c;
    end
    return load_cmd(random_raw());
  endfunction

  task automatic send_word(psbip_in_t cmd);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(99) < 16) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= cmd;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_words.push_back(playback_word(cmd));
  endtask

  // waits for the core to go idle before touching a register
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SAMPLE_FORMAT: fmt_reg    = val[1:0];
      REG_CHANNEL_COUNT: chans_reg  = val[1:0];
      REG_FRAME_COUNT:   frames_reg = val[12:0];
      default:           vol_reg    = val;
    endcase
  endtask

  task automatic test_load_formats();
    send_word(load_cmd(32'h0000_8000));
    send_word(load_cmd(32'hABCD_7FFF));
    write_reg(REG_SAMPLE_FORMAT, FMT_U8);
    send_word(load_cmd(32'h0000_0000));
    send_word(load_cmd(32'hFFFF_FFFF));
    write_reg(REG_SAMPLE_FORMAT, FMT_S24);
    send_word(load_cmd(32'h0080_0000));
    send_word(load_cmd(32'hFF7F_FFFF));
    write_reg(REG_SAMPLE_FORMAT, FMT_F32);
    send_word(load_cmd(32'h3F80_0000));
    send_word(load_cmd(32'hBF80_0000));
    send_word(load_cmd(32'h7F80_0000));
    send_word(load_cmd(32'hFF80_0000));
    send_word(load_cmd(32'h7FC0_0000));
    send_word(load_cmd(32'h8000_0001));
    send_word(load_cmd(32'h4700_0000));
  endtask

  task automatic test_interp_reads();
    write_reg(REG_FRAME_COUNT, 16'd4);
    send_word(read_cmd(2'd3, 12'd3, 16'hFFFF));
    send_word(read_cmd(2'd0, 12'd0, 16'h0000));
    send_word(read_cmd(2'd1, 12'd1, 16'h8000));
    send_word(read_cmd(2'd0, 12'd4, 16'h1234));
    send_word(read_cmd(2'd2, 12'd4095, 16'hFFFF));
    write_reg(REG_VOLUME_Q15, 16'h0000);
    send_word(read_cmd(2'd0, 12'd2, 16'h1234));
    write_reg(REG_VOLUME_Q15, 16'hFFFF);
    send_word(read_cmd(2'd0, 12'd0, 16'h0000));
    send_word(read_cmd(2'd0, 12'd1, 16'h0000));
    write_reg(REG_VOLUME_Q15, 16'h8000);
  endtask

  task automatic test_buffer_full();
    write_reg(REG_FRAME_COUNT, 16'(wr_frame));
    send_word(load_cmd(32'h4000_0000));
    write_reg(REG_FRAME_COUNT, 16'd0);
    send_word(load_cmd(32'h3F00_0000));
    write_reg(REG_FRAME_COUNT, 16'h1FFF);
    send_word(load_cmd(32'h4000_0000));
  endtask

  task automatic test_stale_channel();
    write_reg(REG_SAMPLE_FORMAT, FMT_S16);
    write_reg(REG_CHANNEL_COUNT, 16'd2);
    send_word(load_cmd(32'h0000_1111));
    send_word(load_cmd(32'h0000_2222));
    send_word(load_cmd(32'h0000_3333));
    write_reg(REG_CHANNEL_COUNT, 16'd1);
    send_word(load_cmd(32'h0000_4444));
    write_reg(REG_CHANNEL_COUNT, 16'd0);
    send_word(load_cmd(32'h0000_5555));
    write_reg(REG_CHANNEL_COUNT, 16'd3);
    send_word(load_cmd(32'h0000_6666));
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned lo;
    int unsigned pick;
    logic [15:0] frames_val;
    logic [15:0] vol_val;
    sent    = 0;
    gaps_on = 1'b0;
    while (sent < RANDOM_WORDS) begin
      if (sent >= 150) gaps_on = 1'b1;
      write_reg(REG_SAMPLE_FORMAT, $urandom_range(3));
      write_reg(REG_CHANNEL_COUNT, $urandom_range(3));
      pick = $urandom_range(9);
      case (pick)
        0: frames_val = $urandom_range(1);
        1: frames_val = $urandom_range(1) ? 16'd4096 : 16'h1FFF;
        2: frames_val = $urandom_range(8, 2);
        default: begin
          lo = (wr_frame > 8) ? wr_frame - 8 : 1;
          frames_val = $urandom_range(wr_frame + 4, lo);
        end
      endcase
      write_reg(REG_FRAME_COUNT, frames_val);
      pick = $urandom_range(7);
      case (pick)
        0:       vol_val = 16'h0000;
        1:       vol_val = 16'hFFFF;
        2:       vol_val = 16'h8000;
        default: vol_val = $urandom_range(16'hFFFF);
      endcase
      write_reg(REG_VOLUME_Q15, vol_val);
      repeat ($urandom_range(45, 15)) begin
        send_word(random_cmd());
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_words.size() == 0) begin
        fails++;
        $error("word with none expected: sample_out %0d range_error %0b",
               result_o.sample_out, result_o.range_error);
      end else begin
        want = pending_words.pop_front();
        if (result_o.sample_out !== want.sample_out) begin
          fails++;
          $error("sample_out expected %0d actual %0d", want.sample_out, result_o.sample_out);
        end
        if (result_o.range_error !== want.range_error) begin
          fails++;
          $error("range_error expected %0b actual %0b", want.range_error,
                 result_o.range_error);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || result_valid_o === 1'b1 || cfg_we_i || (start_i && busy_o === 1'b0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** pcm_sample_buffer_interp_playback_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_load_formats();
    test_interp_reads();
    test_buffer_full();
    test_stale_channel();
    test_random_traffic();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (fails == 0)
      $display("** pcm_sample_buffer_interp_playback_core: PASSED **");
    else
      $display("** pcm_sample_buffer_interp_playback_core: FAILED **");
    $finish;
  end

endmodule
